// ===== rtl/core/hpl_pkg.sv =====
// ----------------------------------------------------------------------------
// hpl_pkg
// Shared widths, codes and defaults for the handle pool core.
// ----------------------------------------------------------------------------
package hpl_pkg;

   // Fixed request and response field widths
   localparam int MODE_W    = 2;
   localparam int HANDLE_W  = 7;
   localparam int PAYLOAD_W = 32;
   localparam int TIME_IN_W = 32;
   localparam int STATUS_W  = 2;

   // Defaults for the core parameters
   localparam int POOL_SIZE_DEF  = 64;
   localparam int TIME_WIDTH_DEF = 32;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request operation codes
   localparam mode_type MODE_ADD     = 2'd0;
   localparam mode_type MODE_TAKE    = 2'd1;
   localparam mode_type MODE_RELEASE = 2'd2;

   // Response status codes
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_BAD_HANDLE = 2'd1;
   localparam status_type ST_FULL       = 2'd2;
   localparam status_type ST_EMPTY      = 2'd3;

endpackage

// ===== rtl/core/hpl_if.sv =====
// ----------------------------------------------------------------------------
// hpl_if
// Request and response channels of the handle pool (valid/ready).
// ----------------------------------------------------------------------------
interface hpl_req_if import hpl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [HANDLE_W-1:0]  handle;
   logic [PAYLOAD_W-1:0] payload;
   logic [TIME_IN_W-1:0] timeout;
   logic [TIME_IN_W-1:0] now;

   modport source (output valid, mode, handle, payload, timeout, now, input ready);
   modport sink   (input valid, mode, handle, payload, timeout, now, output ready);
endinterface

interface hpl_rsp_if import hpl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [HANDLE_W-1:0]  handle_out;
   logic [PAYLOAD_W-1:0] payload_out;

   modport source (output valid, status, handle_out, payload_out, input ready);
   modport sink   (input valid, status, handle_out, payload_out, output ready);
endinterface

// ===== rtl/core/hpl_ram.sv =====
// ----------------------------------------------------------------------------
// hpl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hpl_expiry.sv =====
// ----------------------------------------------------------------------------
// hpl_expiry
// Liveness check of one handle table entry against the current time.
// ----------------------------------------------------------------------------
module hpl_expiry #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  used,
   input  logic [TIME_WIDTH-1:0] act_time,
   input  logic [TIME_WIDTH-1:0] limit,
   input  logic [TIME_WIDTH-1:0] now,
   output logic                  alive
);

   logic [TIME_WIDTH-1:0] horizon;

   // Alive: used, limit not past now, last activity after now - limit
   assign horizon = now - limit;
   assign alive   = used && (limit <= now) && (act_time > horizon);

endmodule

// ===== rtl/core/handle_pool_with_liveness_core.sv =====
// ----------------------------------------------------------------------------
// handle_pool_with_liveness_core
// Handle allocator with a LIFO free stack, an alive stack and a per-handle
// table (payload, activity time, idle limit, used and listed flags).
//
//   channel  | dir | handshake   | fields
//   ---------+-----+-------------+------------------------------------------
//   req_if   | in  | valid/ready | mode, handle, payload, timeout, now
//   rsp_if   | out | valid/ready | status, handle_out, payload_out
//
// Allocate passes S_FREE (free stack read), S_TBL and S_OUT from accept to
// response load; refresh and release pass S_TBL and S_OUT; checks that end
// at once go straight to S_OUT. The next request is accepted the cycle after
// the load. Take passes S_ALV and S_TBL (alive stack, then handle table read)
// per popped alive entry, then S_OUT. After reset a clearing pass zeroes the
// handle table and loads the free stack; no request is taken meanwhile.
// A finished response waits in the output register; the next request is
// accepted while it waits, and the core stalls only to load the next one.
// ----------------------------------------------------------------------------
module handle_pool_with_liveness_core import hpl_pkg::*; #(
   parameter int POOL_SIZE  = POOL_SIZE_DEF,
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input logic   clock,
   input logic   reset,
   hpl_req_if.sink   req_if,
   hpl_rsp_if.source rsp_if
);

   // Widths
   localparam int CW    = $clog2(POOL_SIZE + 1);
   localparam int H_W   = (CW > HANDLE_W) ? CW : HANDLE_W;
   localparam int SA_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int TW    = TIME_WIDTH;
   localparam int TBL_W = PAYLOAD_W + 2 * TW + 2;

   // Handle table word layout
   localparam int LISTED_B = 0;
   localparam int USED_B   = 1;
   localparam int LIM_LSB  = 2;
   localparam int ACT_LSB  = 2 + TW;
   localparam int PAY_LSB  = 2 + 2 * TW;

   localparam logic [CW-1:0] POOL_N = CW'(POOL_SIZE);

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FREE  = 3'd2;
   localparam logic [2:0] S_ALV   = 3'd3;
   localparam logic [2:0] S_TBL   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic [CW-1:0] alive_cnt_ff, alive_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Latched request and work registers
   mode_type             op_mode_ff, op_mode_in;
   logic                 op_alloc_ff, op_alloc_in;
   logic [PAYLOAD_W-1:0] op_pay_ff, op_pay_in;
   logic [TW-1:0]        op_tmo_ff, op_tmo_in;
   logic [TW-1:0]        op_now_ff, op_now_in;
   logic [CW-1:0]        cur_h_ff, cur_h_in;

   status_type           res_status_ff, res_status_in;
   logic [CW-1:0]        res_handle_ff, res_handle_in;
   logic [PAYLOAD_W-1:0] res_payload_ff, res_payload_in;

   status_type           rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;

   // Memory ports
   logic             free_wr_en, free_rd_en;
   logic [SA_W-1:0]  free_wr_addr, free_rd_addr;
   logic [CW-1:0]    free_wr_data, free_rd_data;
   logic             alive_wr_en, alive_rd_en;
   logic [SA_W-1:0]  alive_wr_addr, alive_rd_addr;
   logic [CW-1:0]    alive_wr_data, alive_rd_data;
   logic             tbl_wr_en, tbl_rd_en;
   logic [CW-1:0]    tbl_wr_addr, tbl_rd_addr;
   logic [TBL_W-1:0] tbl_wr_data, tbl_rd_data;

   // Request decode helpers
   logic [H_W-1:0] req_h;
   logic           req_h_zero, req_h_high;
   logic           ent_alive;
   logic           ent_used, ent_listed;
   logic [CW-1:0]  free_top, alive_top;

   assign req_h      = H_W'(req_if.handle);
   assign req_h_zero = (req_h == '0);
   assign req_h_high = (req_h > H_W'(POOL_SIZE));
   assign ent_used   = tbl_rd_data[USED_B];
   assign ent_listed = tbl_rd_data[LISTED_B];
   assign free_top   = free_cnt_ff - 1'b1;
   assign alive_top  = alive_cnt_ff - 1'b1;

   // Free handle stack
   hpl_ram #(.WIDTH(CW), .DEPTH(POOL_SIZE)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (free_wr_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_rd_data)
   );

   // Alive handle stack
   hpl_ram #(.WIDTH(CW), .DEPTH(POOL_SIZE)) u_alive_ram (
      .clock   (clock),
      .wr_en   (alive_wr_en),
      .wr_addr (alive_wr_addr),
      .wr_data (alive_wr_data),
      .rd_en   (alive_rd_en),
      .rd_addr (alive_rd_addr),
      .rd_data (alive_rd_data)
   );

   // Handle table, indexed by handle (entry 0 unused)
   hpl_ram #(.WIDTH(TBL_W), .DEPTH(POOL_SIZE + 1)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // Expiry check on the entry just read
   hpl_expiry #(.TIME_WIDTH(TW)) u_expiry (
      .used     (ent_used),
      .act_time (tbl_rd_data[ACT_LSB +: TW]),
      .limit    (tbl_rd_data[LIM_LSB +: TW]),
      .now      (op_now_ff),
      .alive    (ent_alive)
   );

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.handle_out  = rsp_handle_ff;
   assign rsp_if.payload_out = rsp_payload_ff;

   // Sequencer: every table write completes before the next table read,
   // and the alive stack never holds a handle twice, so no forwarding
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      free_cnt_in    = free_cnt_ff;
      alive_cnt_in   = alive_cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      op_mode_in     = op_mode_ff;
      op_alloc_in    = op_alloc_ff;
      op_pay_in      = op_pay_ff;
      op_tmo_in      = op_tmo_ff;
      op_now_in      = op_now_ff;
      cur_h_in       = cur_h_ff;
      res_status_in  = res_status_ff;
      res_handle_in  = res_handle_ff;
      res_payload_in = res_payload_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_payload_in = rsp_payload_ff;

      free_wr_en    = 1'b0;
      free_wr_addr  = '0;
      free_wr_data  = '0;
      free_rd_en    = 1'b0;
      free_rd_addr  = '0;
      alive_wr_en   = 1'b0;
      alive_wr_addr = '0;
      alive_wr_data = '0;
      alive_rd_en   = 1'b0;
      alive_rd_addr = '0;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = '0;
      tbl_wr_data   = '0;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = '0;

      // Response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // Zero the table entry and preload the free stack slot
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr_ff;
            if (clr_ff < POOL_N) begin
               free_wr_en   = 1'b1;
               free_wr_addr = clr_ff[SA_W-1:0];
               free_wr_data = clr_ff + 1'b1;
            end
            if (clr_ff == POOL_N) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_if.valid) begin
               op_mode_in     = req_if.mode;
               op_alloc_in    = 1'b0;
               op_pay_in      = req_if.payload;
               op_tmo_in      = TW'(req_if.timeout);
               op_now_in      = TW'(req_if.now);
               cur_h_in       = req_h[CW-1:0];
               res_status_in  = ST_OK;
               res_handle_in  = '0;
               res_payload_in = '0;
               unique case (req_if.mode)
                  MODE_ADD: begin
                     if (req_h_zero) begin
                        if (free_cnt_ff == '0) begin
                           res_status_in = ST_FULL;
                           state_in      = S_OUT;
                        end else begin
                           op_alloc_in  = 1'b1;
                           free_rd_en   = 1'b1;
                           free_rd_addr = free_top[SA_W-1:0];
                           free_cnt_in  = free_top;
                           state_in     = S_FREE;
                        end
                     end else if (req_h_high) begin
                        res_status_in = ST_BAD_HANDLE;
                        state_in      = S_OUT;
                     end else begin
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = req_h[CW-1:0];
                        state_in    = S_TBL;
                     end
                  end
                  MODE_TAKE: begin
                     if (alive_cnt_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_OUT;
                     end else begin
                        alive_rd_en   = 1'b1;
                        alive_rd_addr = alive_top[SA_W-1:0];
                        alive_cnt_in  = alive_top;
                        state_in      = S_ALV;
                     end
                  end
                  MODE_RELEASE: begin
                     if (req_h_zero || req_h_high) begin
                        res_status_in = ST_BAD_HANDLE;
                        state_in      = S_OUT;
                     end else begin
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = req_h[CW-1:0];
                        state_in    = S_TBL;
                     end
                  end
                  default: begin
                     res_status_in = ST_BAD_HANDLE;
                     state_in      = S_OUT;
                  end
               endcase
            end
         end

         S_FREE: begin
            // Popped handle arrives; fetch its table entry
            cur_h_in    = free_rd_data;
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = free_rd_data;
            state_in    = S_TBL;
         end

         S_ALV: begin
            cur_h_in    = alive_rd_data;
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = alive_rd_data;
            state_in    = S_TBL;
         end

         S_TBL: begin
            case (op_mode_ff)
               MODE_ADD: begin
                  // Rewrite entry, mark listed, push alive if it was not
                  tbl_wr_en   = 1'b1;
                  tbl_wr_addr = cur_h_ff;
                  tbl_wr_data = {op_pay_ff, op_now_ff, op_tmo_ff,
                                 op_alloc_ff | ent_used, 1'b1};
                  if (!ent_listed && (alive_cnt_ff < POOL_N)) begin
                     alive_wr_en   = 1'b1;
                     alive_wr_addr = alive_cnt_ff[SA_W-1:0];
                     alive_wr_data = cur_h_ff;
                     alive_cnt_in  = alive_cnt_ff + 1'b1;
                  end
                  res_handle_in = cur_h_ff;
                  state_in      = S_OUT;
               end
               MODE_RELEASE: begin
                  if (!ent_used || (free_cnt_ff >= POOL_N)) begin
                     res_status_in = ST_BAD_HANDLE;
                  end else begin
                     tbl_wr_en           = 1'b1;
                     tbl_wr_addr         = cur_h_ff;
                     tbl_wr_data         = tbl_rd_data;
                     tbl_wr_data[USED_B] = 1'b0;
                     free_wr_en          = 1'b1;
                     free_wr_addr        = free_cnt_ff[SA_W-1:0];
                     free_wr_data        = cur_h_ff;
                     free_cnt_in         = free_cnt_ff + 1'b1;
                  end
                  state_in = S_OUT;
               end
               MODE_TAKE: begin
                  // Unlist the popped entry, stop at the first live one
                  tbl_wr_en             = 1'b1;
                  tbl_wr_addr           = cur_h_ff;
                  tbl_wr_data           = tbl_rd_data;
                  tbl_wr_data[LISTED_B] = 1'b0;
                  if (ent_alive) begin
                     res_payload_in = tbl_rd_data[PAY_LSB +: PAYLOAD_W];
                     state_in       = S_OUT;
                  end else if (alive_cnt_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_OUT;
                  end else begin
                     alive_rd_en   = 1'b1;
                     alive_rd_addr = alive_top[SA_W-1:0];
                     alive_cnt_in  = alive_top;
                     state_in      = S_ALV;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end

         S_OUT: begin
            // Load the response once the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_handle_in  = HANDLE_W'(res_handle_ff);
               rsp_payload_in = res_payload_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_cnt_ff  <= POOL_N;
         alive_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_cnt_ff  <= free_cnt_in;
         alive_cnt_ff <= alive_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_mode_ff     <= op_mode_in;
      op_alloc_ff    <= op_alloc_in;
      op_pay_ff      <= op_pay_in;
      op_tmo_ff      <= op_tmo_in;
      op_now_ff      <= op_now_in;
      cur_h_ff       <= cur_h_in;
      res_status_ff  <= res_status_in;
      res_handle_ff  <= res_handle_in;
      res_payload_ff <= res_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Stack counts stay within the pool
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (free_cnt_ff <= POOL_N) && (alive_cnt_ff <= POOL_N))
      else $error("stack count beyond pool size");

   // Free count moves by at most one per cycle
   a_free_step: assert property (@(posedge clock) disable iff (reset)
      (free_cnt_ff != $past(free_cnt_ff)) |->
         ((free_cnt_ff == CW'($past(free_cnt_ff) + 1'b1)) ||
          (free_cnt_ff == CW'($past(free_cnt_ff) - 1'b1))))
      else $error("free count jumped");

   // Table read never hits the entry being written in the same cycle
   a_tbl_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (tbl_wr_en && tbl_rd_en) |-> (tbl_wr_addr != tbl_rd_addr))
      else $error("table read and write collide");

   // An accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff != S_IDLE))
      else $error("request accepted without work");

endmodule
